/* design/vse_pkg.sv */
package vse_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int LOG_ITER  = 30;
  localparam int INT_W     = 7;
  localparam int LOG_W     = INT_W + LOG_ITER;

  typedef enum logic [2:0] {
    MODEL_SPHERICAL   = 3'd0,
    MODEL_POWER       = 3'd1,
    MODEL_GAUSSIAN    = 3'd2,
    MODEL_EXPONENTIAL = 3'd3,
    MODEL_LOG         = 3'd4
  } model_t;

  typedef enum logic [2:0] {
    REG_MODEL  = 3'd0,
    REG_RANGE  = 3'd1,
    REG_SILL   = 3'd2,
    REG_NUGGET = 3'd3,
    REG_MAXLAG = 3'd4,
    REG_POWEXP = 3'd5
  } reg_index_t;

  // floor square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem_v;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem_v = v;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem_v >= res + bit_v) begin
        rem_v = rem_v - (res + bit_v);
        res   = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(2^(pos-30)) in Q30, the factor used for fraction bit pos
  function automatic logic [63:0] pow2_fac(input int pos);
    logic [63:0] fac;
    fac = 64'd1 << 31;
    for (int b = 30; b > pos; b--) begin
      fac = isqrt64(fac << 30);
    end
    return fac;
  endfunction

  // a*b >> 30 in two partial products
  function automatic logic [49:0] mulq(input logic [43:0] a, input logic [35:0] b);
    logic [64:0] hi;
    logic [58:0] lo;
    hi = a * b[35:15];
    lo = a * b[14:0];
    return 50'((hi >> 15) + 65'(lo >> 30));
  endfunction

endpackage

/* design/variogram_semivariance_eval.sv */
// variogram semivariance evaluator, fully pipelined
// throughput: one lag distance per cycle, busy stays low; the 41-step divider
//   and the two 31-stage log2 and 2^x chains set the depth, not the rate
// reset: synchronous rst clears the pipe and loads the register defaults
// the receiver cannot stall: each result is shown for exactly one cycle
module variogram_semivariance_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        lag_distance,
  input  logic               last_in,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               result_valid,
  output logic signed [31:0] semivariance,
  output logic               error_flag,
  output logic               last_out
);

  localparam int LOG_LAT   = vse_pkg::LOG_ITER + 1;
  localparam int DIV_STEPS = 41;
  localparam int POW_STEPS = 31;
  localparam logic [40:0] CAP       = 41'd1 << 40;
  localparam logic [35:0] LOG2E_Q30 = 36'd1549082005;
  localparam logic [30:0] Q30_ONE   = 31'd1 << 30;
  localparam logic [31:0] UNIT      = 32'd1 << vse_pkg::FRAC_BITS;

  // per-item working set; fields fill in as the item moves down the pipe
  typedef struct packed {
    logic                valid;
    logic                last;
    vse_pkg::model_t     mode;
    logic [31:0]         d;
    logic                d_zero;
    logic                neg;
    logic [31:0]         amag;
    logic                sph_full;
    logic                log_d_neg;
    logic signed [30:0]  ld;
    logic signed [30:0]  lm;
    logic signed [37:0]  diff;
    logic [61:0]         nprod;
    logic signed [54:0]  eprod;
    logic signed [46:0]  e;
    logic [63:0]         div_n;
    logic [31:0]         div_d;
    logic [31:0]         rem;
    logic                sat;
    logic [40:0]         q;
    logic [35:0]         r36;
    logic [49:0]         m1;
    logic [49:0]         m2;
    logic [30:0]         s;
    logic                tzero;
    logic [4:0]          kshift;
    logic signed [16:0]  kp;
    logic [30:0]         u;
    logic [31:0]         acc;
    logic [31:0]         opnd;
    logic [63:0]         prod;
    logic [40:0]         mag;
    logic                err;
    logic                zero_out;
  } work_t;

  // configuration registers
  vse_pkg::model_t model_select;
  logic [31:0]     model_range;
  logic [31:0]     sill_level;
  logic [31:0]     nugget_level;
  logic [31:0]     max_lag_distance;
  logic [15:0]     power_exponent;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_select     <= vse_pkg::MODEL_SPHERICAL;
      model_range      <= UNIT;
      sill_level       <= UNIT;
      nugget_level     <= '0;
      max_lag_distance <= UNIT;
      power_exponent   <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vse_pkg::reg_index_t'(cfg_index))
        vse_pkg::REG_MODEL:  model_select     <= vse_pkg::model_t'(cfg_data[2:0]);
        vse_pkg::REG_RANGE:  model_range      <= cfg_data;
        vse_pkg::REG_SILL:   sill_level       <= cfg_data;
        vse_pkg::REG_NUGGET: nugget_level     <= cfg_data;
        vse_pkg::REG_MAXLAG: max_lag_distance <= cfg_data;
        vse_pkg::REG_POWEXP: power_exponent   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- entry
  // log2 of the lag and of the maximum lag run alongside a delay line
  logic signed [vse_pkg::LOG_W-1:0] log_d;
  logic signed [vse_pkg::LOG_W-1:0] log_m;

  vse_log2 u_log_d (.clk(clk), .raw(lag_distance),     .log2_val(log_d));
  vse_log2 u_log_m (.clk(clk), .raw(max_lag_distance), .log2_val(log_m));

  work_t sa [0:LOG_LAT-1];
  work_t sa_next;

  always_comb begin
    sa_next          = '0;
    sa_next.valid    = start && !busy;
    sa_next.last     = last_in;
    sa_next.mode     = model_select;
    sa_next.d        = lag_distance;
    sa_next.d_zero   = (lag_distance == '0);
    sa_next.neg      = (sill_level < nugget_level);
    sa_next.amag     = (sill_level < nugget_level) ? (nugget_level - sill_level)
                                                   : (sill_level - nugget_level);
    // spherical gives the whole sill at zero lag or at or beyond the range
    sa_next.sph_full = (lag_distance == '0) || (lag_distance >= model_range);
  end

  always_ff @(posedge clk) begin
    if (rst) sa[0] <= '0;
    else     sa[0] <= sa_next;
  end

  for (genvar i = 0; i < LOG_LAT - 1; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) sa[i+1] <= '0;
      else     sa[i+1] <= sa[i];
    end
  end

  // ---------------------------------------------------------------- log terms
  work_t sb1, sb1_next, sb2, sb2_next, sb3, sb3_next, sc0, sc0_next;
  logic signed [vse_pkg::LOG_W-1:0] log_d_adj;
  logic signed [vse_pkg::LOG_W-1:0] log_m_adj;
  logic [29:0] ald;
  logic [29:0] alm;
  logic signed [54:0] eround;

  // log2 to Q24, truncated toward zero
  always_comb begin
    sb1_next           = sa[LOG_LAT-1];
    log_d_adj          = log_d[vse_pkg::LOG_W-1] ? (log_d + 63) : log_d;
    log_m_adj          = log_m[vse_pkg::LOG_W-1] ? (log_m + 63) : log_m;
    sb1_next.log_d_neg = log_d[vse_pkg::LOG_W-1];
    sb1_next.ld        = 31'(log_d_adj >>> 6);
    sb1_next.lm        = (max_lag_distance != '0) ? 31'(log_m_adj >>> 6) : '0;
    sb1_next.diff      = 38'(log_d) - 38'(log_m);
  end

  // amag*|log d| for the ratio, p*(log d - log max) for the power model
  always_comb begin
    sb2_next       = sb1;
    ald            = 30'(sb1.ld[30] ? -sb1.ld : sb1.ld);
    sb2_next.nprod = sb1.amag * ald;
    sb2_next.eprod = $signed({1'b0, power_exponent}) * sb1.diff;
  end

  // exponent back to Q30 and divider operands
  always_comb begin
    sb3_next   = sb2;
    eround     = sb2.eprod[54] ? (sb2.eprod + 55'sd255) : sb2.eprod;
    sb3_next.e = 47'(eround >>> 8);
    alm        = 30'(sb2.lm[30] ? -sb2.lm : sb2.lm);
    if (sb2.mode == vse_pkg::MODEL_LOG) begin
      sb3_next.div_n = {2'b0, sb2.nprod};
      sb3_next.div_d = {2'b0, alm};
    end else begin
      sb3_next.div_n = {2'b0, sb2.d, 30'b0};
      sb3_next.div_d = model_range;
    end
  end

  // quotient past 41 bits is flagged as overflow up front
  always_comb begin
    sc0_next       = sb3;
    sc0_next.rem   = {9'b0, sb3.div_n[63:41]};
    sc0_next.sat   = ({9'b0, sb3.div_n[63:41]} >= sb3.div_d);
    sc0_next.div_n = {23'b0, sb3.div_n[40:0]};
    sc0_next.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb1 <= '0;
      sb2 <= '0;
      sb3 <= '0;
      sc0 <= '0;
    end else begin
      sb1 <= sb1_next;
      sb2 <= sb2_next;
      sb3 <= sb3_next;
      sc0 <= sc0_next;
    end
  end

  // ---------------------------------------------------------------- divider
  // restoring division, one quotient bit per stage
  work_t sc [0:DIV_STEPS];
  assign sc[0] = sc0;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    work_t nx;
    logic [32:0] re;
    logic        ge;
    always_comb begin
      nx       = sc[i];
      re       = {sc[i].rem, sc[i].div_n[40]};
      ge       = (re >= {1'b0, sc[i].div_d});
      nx.rem   = ge ? 32'(re - {1'b0, sc[i].div_d}) : re[31:0];
      nx.div_n = sc[i].div_n << 1;
      nx.q     = {sc[i].q[39:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) sc[i+1] <= '0;
      else     sc[i+1] <= nx;
    end
  end

  // ---------------------------------------------------------------- r terms
  work_t sd1, sd1_next, sd2, sd2_next;
  work_t se [0:POW_STEPS];
  work_t sd3_next;
  logic [43:0] a2;
  logic [35:0] b2;
  logic [31:0] three_r;
  logic [31:0] s_diff;
  logic [49:0] yv;

  // r^2 for spherical and Gaussian, r*log2(e) for exponential
  always_comb begin
    sd1_next     = sc[DIV_STEPS];
    sd1_next.r36 = sc[DIV_STEPS].q[35:0];
    sd1_next.m1  = vse_pkg::mulq({8'b0, sc[DIV_STEPS].q[35:0]},
                                 (sc[DIV_STEPS].mode == vse_pkg::MODEL_EXPONENTIAL)
                                   ? LOG2E_Q30 : sc[DIV_STEPS].q[35:0]);
    // exp(-x) taken as zero for very large r
    if (sc[DIV_STEPS].mode == vse_pkg::MODEL_EXPONENTIAL) begin
      sd1_next.tzero = sc[DIV_STEPS].sat || (sc[DIV_STEPS].q[40:36] != '0);
    end else begin
      sd1_next.tzero = sc[DIV_STEPS].sat || (sc[DIV_STEPS].q[40:33] != '0);
    end
  end

  // r^3 for spherical, 3r^2*log2(e) for Gaussian
  always_comb begin
    sd2_next = sd1;
    if (sd1.mode == vse_pkg::MODEL_SPHERICAL) begin
      a2 = sd1.m1[43:0];
      b2 = sd1.r36;
    end else begin
      a2 = 44'({2'b0, sd1.m1[41:0]} + {1'b0, sd1.m1[41:0], 1'b0});
      b2 = LOG2E_Q30;
    end
    sd2_next.m2 = vse_pkg::mulq(a2, b2);
  end

  // spherical shape, and the 2^x argument split into shift and fraction
  always_comb begin
    sd3_next        = sd2;
    three_r         = {1'b0, sd2.r36[29:0], 1'b0} + {2'b0, sd2.r36[29:0]};
    s_diff          = three_r - {2'b0, sd2.m2[29:0]};
    sd3_next.s      = s_diff[31:1];
    yv              = (sd2.mode == vse_pkg::MODEL_EXPONENTIAL) ? sd2.m1 : sd2.m2;
    sd3_next.tzero  = sd2.tzero || (yv[49:30] >= 20'd31);
    sd3_next.kshift = yv[34:30];
    sd3_next.kp     = $signed(sd2.e[46:30]);
    if (sd2.mode == vse_pkg::MODEL_POWER) begin
      sd3_next.u = {1'b0, sd2.e[29:0]};
    end else begin
      sd3_next.u = Q30_ONE - {1'b0, yv[29:0]};
    end
    sd3_next.acc = {1'b0, Q30_ONE};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd1   <= '0;
      sd2   <= '0;
      se[0] <= '0;
    end else begin
      sd1   <= sd1_next;
      sd2   <= sd2_next;
      se[0] <= sd3_next;
    end
  end

  // ---------------------------------------------------------------- 2^x
  // product of 2^(2^-i) factors, most significant fraction bit first
  for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow
    localparam logic [31:0] FAC = 32'(vse_pkg::pow2_fac(POW_STEPS - 1 - j));
    work_t nx;
    logic [63:0] pp;
    always_comb begin
      nx = se[j];
      pp = se[j].acc * FAC;
      if (se[j].u[POW_STEPS-1-j]) nx.acc = pp[61:30];
    end
    always_ff @(posedge clk) begin
      if (rst) se[j+1] <= '0;
      else     se[j+1] <= nx;
    end
  end

  // ---------------------------------------------------------------- scale
  work_t sf1, sf1_next, sf2, sf2_next, sf3, sf3_next;
  logic [31:0]        tval;
  logic signed [17:0] sh;
  logic [17:0]        nsh;
  logic               down;

  // multiplier operand per model
  always_comb begin
    sf1_next = se[POW_STEPS];
    tval     = se[POW_STEPS].tzero ? '0
             : (se[POW_STEPS].acc >> ({1'b0, se[POW_STEPS].kshift} + 6'd1));
    case (se[POW_STEPS].mode)
      vse_pkg::MODEL_SPHERICAL: sf1_next.opnd = {1'b0, se[POW_STEPS].s};
      vse_pkg::MODEL_POWER:     sf1_next.opnd = se[POW_STEPS].acc;
      default:                  sf1_next.opnd = {1'b0, Q30_ONE} - tval;
    endcase
  end

  always_comb begin
    sf2_next      = sf1;
    sf2_next.prod = sf1.amag * sf1.opnd;
  end

  // magnitude, direction and error per model, special cases included
  always_comb begin
    sf3_next          = sf2;
    sf3_next.err      = 1'b0;
    sf3_next.zero_out = 1'b0;
    sf3_next.mag      = '0;
    sh                = 18'(sf2.kp) - 18'sd30;
    nsh               = 18'(-sh);
    down              = 1'b0;
    case (sf2.mode) inside
      vse_pkg::MODEL_SPHERICAL: begin
        sf3_next.mag = sf2.sph_full ? {9'b0, sf2.amag} : 41'(sf2.prod >> 30);
      end
      vse_pkg::MODEL_GAUSSIAN, vse_pkg::MODEL_EXPONENTIAL: begin
        if (model_range == '0) begin
          sf3_next.err = 1'b1;
          sf3_next.mag = {9'b0, sf2.amag};
        end else begin
          sf3_next.mag = 41'(sf2.prod >> 30);
        end
      end
      vse_pkg::MODEL_POWER: begin
        if (power_exponent == '0) begin
          sf3_next.mag = {9'b0, sf2.amag};
        end else if (max_lag_distance == '0) begin
          sf3_next.err = 1'b1;
          sf3_next.mag = (sf2.amag != '0) ? CAP : '0;
        end else if (sf2.d_zero || sf2.prod == '0) begin
          sf3_next.mag = '0;
        end else if (sh <= 0) begin
          sf3_next.mag = (nsh >= 18'd64) ? '0 : 41'(sf2.prod >> nsh[5:0]);
        end else if (sh >= 40) begin
          sf3_next.mag = CAP;
        end else if (sf2.prod > (64'(CAP) >> sh[5:0])) begin
          sf3_next.mag = CAP;
        end else begin
          sf3_next.mag = 41'(sf2.prod << sh[5:0]);
        end
      end
      vse_pkg::MODEL_LOG: begin
        if (sf2.d_zero || sf2.lm == '0) begin
          // log of zero or a zero divisor saturates away from the nugget
          sf3_next.err = 1'b1;
          if (sf2.amag != '0) begin
            down = sf2.d_zero ? !((max_lag_distance != '0) && sf2.lm[30])
                              : sf2.log_d_neg;
            sf3_next.mag = CAP;
            sf3_next.neg = sf2.neg ^ down;
          end
        end else begin
          sf3_next.mag = (sf2.sat || sf2.q > CAP) ? CAP : sf2.q;
          sf3_next.neg = sf2.neg ^ (sf2.ld[30] ^ sf2.lm[30]);
        end
      end
      default: sf3_next.zero_out = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sf1 <= '0;
      sf2 <= '0;
      sf3 <= '0;
    end else begin
      sf1 <= sf1_next;
      sf2 <= sf2_next;
      sf3 <= sf3_next;
    end
  end

  // ---------------------------------------------------------------- output
  // nugget plus or minus the magnitude, clamped to 32 bits signed
  logic signed [42:0] vsum;
  logic signed [31:0] res_val;
  logic               res_err;

  always_comb begin
    vsum = sf3.neg ? ($signed({11'b0, nugget_level}) - $signed({2'b0, sf3.mag}))
                   : ($signed({11'b0, nugget_level}) + $signed({2'b0, sf3.mag}));
    res_err = sf3.err;
    if (sf3.zero_out) begin
      res_val = '0;
      res_err = 1'b0;
    end else if (vsum > 43'sd2147483647) begin
      res_val = 32'sh7fffffff;
      res_err = 1'b1;
    end else if (vsum < -43'sd2147483648) begin
      res_val = 32'sh80000000;
      res_err = 1'b1;
    end else begin
      res_val = 32'(vsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= sf3.valid;
    end
    semivariance <= res_val;
    error_flag   <= res_err;
    last_out     <= sf3.last;
  end

endmodule

/* design/vse_log2.sv */
module vse_log2 (
  input  logic                                clk,
  input  logic [vse_pkg::DATA_W-1:0]          raw,
  output logic signed [vse_pkg::LOG_W-1:0]    log2_val
);

  localparam int N = vse_pkg::LOG_ITER;

  logic [30:0]                 mant  [0:N];
  logic [vse_pkg::INT_W-1:0]   ipart [0:N];
  logic [N-1:0]                frac  [0:N];

  logic [4:0]  msb;
  logic [30:0] mant0;

  // leading one and normalisation into [1,2) at Q30
  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (raw[i]) msb = 5'(i);
    end
    if (raw[31]) begin
      mant0 = raw[31:1];
    end else begin
      mant0 = 31'(raw << (5'd30 - msb));
    end
  end

  always_ff @(posedge clk) begin
    mant[0]  <= mant0;
    ipart[0] <= vse_pkg::INT_W'(msb) - vse_pkg::INT_W'(vse_pkg::FRAC_BITS);
    frac[0]  <= '0;
  end

  // one fraction bit per stage by squaring
  for (genvar i = 0; i < N; i++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] msq;
    always_comb begin
      sq  = mant[i] * mant[i];
      msq = sq[61:30];
    end
    always_ff @(posedge clk) begin
      mant[i+1]  <= msq[31] ? msq[31:1] : msq[30:0];
      frac[i+1]  <= {frac[i][N-2:0], msq[31]};
      ipart[i+1] <= ipart[i];
    end
  end

  assign log2_val = {ipart[N], frac[N]};

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned MAG_LIMIT = 64'd1 << 40;
  localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
  localparam int LATENCY = 114;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [31:0]        lag_distance;
  logic               last_in;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               result_valid;
  logic signed [31:0] semivariance;
  logic               error_flag;
  logic               last_out;

  typedef struct {
    logic [31:0] lag;
    logic signed [31:0] gamma;
    logic        err;
    logic        last;
  } gamma_exp_t;

  // floor square root, bit by bit
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // q30 product, split so nothing overflows 64 bits
  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return ((a * (b >> 15)) >> 15) + ((a * (b & 64'h7FFF)) >> 30);
  endfunction

  // 2^u for u in [0,1] as q30
  function automatic longint unsigned exp2_frac(longint unsigned u);
    longint unsigned acc, fac;
    acc = ONE_Q30;
    fac = 2 * ONE_Q30;
    for (int b = 30; b >= 0; b--) begin
      if (u[b]) acc = (acc * fac) >> 30;
      fac = floor_root(fac << 30);
    end
    return acc;
  endfunction

  function automatic longint unsigned exp2_neg(longint unsigned y);
    longint unsigned k, f;
    k = y >> 30;
    f = y & (ONE_Q30 - 1);
    if (k >= 31) return 0;
    return exp2_frac(ONE_Q30 - f) >> (k + 1);
  endfunction

  // log2 of an unsigned q16.16 value, signed q30
  function automatic longint log2_fix(logic [31:0] raw);
    int p;
    longint unsigned m, frac;
    p = 31;
    frac = 0;
    while (!raw[p]) p--;
    m = (p <= 30) ? (64'(raw) << (30 - p)) : (64'(raw) >> 1);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 2 * ONE_Q30) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p - vse_pkg::FRAC_BITS) * longint'(ONE_Q30) + longint'(frac);
  endfunction

  // magnitude times 2^e, e signed q30, capped
  function automatic longint unsigned scale_by_pow2(longint unsigned amag, longint e);
    longint k, sh;
    longint unsigned f, prod, ue, kk;
    if (e >= 0) begin
      k = e >>> 30;
      f = longint'(e) & (ONE_Q30 - 1);
    end else begin
      ue = -e;
      kk = (ue + ONE_Q30 - 1) >> 30;
      k = -longint'(kk);
      f = (kk << 30) - ue;
    end
    prod = amag * exp2_frac(f);
    if (prod == 0) return 0;
    sh = k - 30;
    if (sh <= 0) begin
      if (-sh >= 64) return 0;
      return prod >> (-sh);
    end
    if (sh >= 40 || prod > (MAG_LIMIT >> sh)) return MAG_LIMIT;
    return prod << sh;
  endfunction

  class gamma_scoreboard;
    logic [2:0]  sel;
    logic [31:0] rng, sill, nug, maxlag;
    logic [15:0] pexp;
    gamma_exp_t  pending_q[$];
    int          mismatches;
    int          checked;
    int          flagged;

    function new();
      sel = vse_pkg::MODEL_SPHERICAL;
      rng = 32'd65536;
      sill = 32'd65536;
      nug = 0;
      maxlag = 32'd65536;
      pexp = 16'd256;
    endfunction

    function void mirror(logic [2:0] idx, logic [31:0] val);
      case (idx)
        vse_pkg::REG_MODEL:  sel = val[2:0];
        vse_pkg::REG_RANGE:  rng = val;
        vse_pkg::REG_SILL:   sill = val;
        vse_pkg::REG_NUGGET: nug = val;
        vse_pkg::REG_MAXLAG: maxlag = val;
        vse_pkg::REG_POWEXP: pexp = val[15:0];
        default: ;
      endcase
    endfunction

    // expected semivariance for one lag at the current settings
    function void note(logic [31:0] d, logic last);
      gamma_exp_t x;
      bit neg, err, mvalid, down;
      longint unsigned amag, mag, r, r3, t, ald, alm;
      longint v, diff, e, lm, ld;
      neg = sill < nug;
      amag = neg ? 64'(nug - sill) : 64'(sill - nug);
      mag = 0;
      err = 0;
      x.lag = d;
      x.last = last;
      if (sel > vse_pkg::MODEL_LOG) begin
        x.gamma = 0;
        x.err = 0;
        pending_q.push_back(x);
        return;
      end
      case (sel)
        vse_pkg::MODEL_SPHERICAL: begin
          if (d > 0 && d < rng) begin
            r = (64'(d) << 30) / 64'(rng);
            r3 = q30_mul(q30_mul(r, r), r);
            mag = (amag * ((3 * r - r3) >> 1)) >> 30;
          end else begin
            mag = amag;
          end
        end
        vse_pkg::MODEL_POWER: begin
          if (pexp == 0) mag = amag;
          else if (maxlag == 0) begin
            err = 1;
            mag = (amag != 0) ? MAG_LIMIT : 0;
          end else if (d == 0) mag = 0;
          else begin
            diff = log2_fix(d) - log2_fix(maxlag);
            e = (longint'(pexp) * diff) / 256;
            mag = scale_by_pow2(amag, e);
          end
        end
        vse_pkg::MODEL_GAUSSIAN, vse_pkg::MODEL_EXPONENTIAL: begin
          if (rng == 0) begin
            err = 1;
            mag = amag;
          end else begin
            r = (64'(d) << 30) / 64'(rng);
            if (sel == vse_pkg::MODEL_EXPONENTIAL)
              t = (r >= 64 * ONE_Q30) ? 0 : exp2_neg(q30_mul(r, LOG2E_Q30));
            else
              t = (r >= 8 * ONE_Q30) ? 0 : exp2_neg(q30_mul(3 * q30_mul(r, r), LOG2E_Q30));
            mag = (amag * (ONE_Q30 - t)) >> 30;
          end
        end
        default: begin
          mvalid = maxlag != 0;
          lm = mvalid ? log2_fix(maxlag) / 64 : 0;
          if (d == 0 || lm == 0) begin
            err = 1;
            if (amag != 0) begin
              down = (d == 0) ? !(mvalid && lm < 0) : (log2_fix(d) < 0);
              mag = MAG_LIMIT;
              neg = neg != down;
            end
          end else begin
            ld = log2_fix(d) / 64;
            ald = (ld < 0) ? -ld : ld;
            alm = (lm < 0) ? -lm : lm;
            mag = (amag * ald) / alm;
            if (mag > MAG_LIMIT) mag = MAG_LIMIT;
            neg = neg != ((ld < 0) != (lm < 0));
          end
        end
      endcase
      v = neg ? longint'(64'(nug)) - longint'(mag) : longint'(64'(nug)) + longint'(mag);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        err = 1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        err = 1;
      end
      x.gamma = v[31:0];
      x.err = err;
      pending_q.push_back(x);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check(logic signed [31:0] g, logic err, logic last);
      gamma_exp_t x;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", g));
        return;
      end
      x = pending_q.pop_front();
      checked++;
      if (err) flagged++;
      if (g !== x.gamma || err !== x.err || last !== x.last)
        report($sformatf("lag %h: got %h/%b/%b want %h/%b/%b",
                         x.lag, g, err, last, x.gamma, x.err, x.last));
    endtask
  endclass

  gamma_scoreboard sb;
  int cycles;
  int phases;

  variogram_semivariance_eval uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lag_distance(lag_distance), .last_in(last_in),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .semivariance(semivariance),
    .error_flag(error_flag), .last_out(last_out)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result monitor, the receiver never stalls
  always @(posedge clk) begin
    if (!rst && result_valid && sb != null)
      sb.check(semivariance, error_flag, last_out);
  end

  // one register transfer, called at a falling edge
  task write_reg(vse_pkg::reg_index_t idx, logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.mirror(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // wait for the pipe to drain, then load a full setting
  task load_setting(logic [2:0] sel, logic [31:0] rng, logic [31:0] sill,
                    logic [31:0] nug, logic [31:0] maxlag, logic [15:0] pexp);
    start = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    write_reg(vse_pkg::REG_MODEL, {29'd0, sel});
    write_reg(vse_pkg::REG_RANGE, rng);
    write_reg(vse_pkg::REG_SILL, sill);
    write_reg(vse_pkg::REG_NUGGET, nug);
    write_reg(vse_pkg::REG_MAXLAG, maxlag);
    write_reg(vse_pkg::REG_POWEXP, {16'd0, pexp});
    phases++;
  endtask

  // one lag transfer; start stays high across back-to-back items
  task send_lag(logic [31:0] d, logic last, int gap);
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    start = 1;
    lag_distance = d;
    last_in = last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(d, last);
    @(negedge clk);
  endtask

  function automatic int draw_gap();
    // long runs with no idling now and then
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [31:0] draw_lag(logic [31:0] rng, logic [31:0] maxlag);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      3: return rng + $urandom_range(0, 8) - 4;
      4: return maxlag + $urandom_range(0, 8) - 4;
      5: return $urandom_range(0, 32'h0002_0000);
      6: return $urandom_range(0, rng);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [31:0] draw_level();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom() >> $urandom_range(8, 31);
    endcase
  endfunction

  initial begin
    logic [2:0]  sel;
    logic [31:0] rng, sill, nug, maxlag;
    logic [15:0] pexp;
    sb = new();
    rst = 1;
    start = 0;
    lag_distance = 0;
    last_in = 0;
    cfg_valid = 0;
    cfg_index = vse_pkg::REG_MODEL;
    cfg_data = 0;
    phases = 0;
    repeat (10) @(negedge clk);
    rst = 0;

    // reset defaults: spherical, unit range and sill
    send_lag(0, 0, 0);
    send_lag(1, 1, 0);
    send_lag(32'd65535, 0, 2);
    send_lag(32'd65536, 0, 0);
    send_lag(32'hFFFF_FFFF, 1, 1);
    // spherical with full sill saturates at zero lag
    load_setting(vse_pkg::MODEL_SPHERICAL, 0, 32'hFFFF_FFFF, 0, 32'd65536, 16'd256);
    send_lag(0, 1, 0);
    // power: zero exponent, then zero max lag, then zero distance
    load_setting(vse_pkg::MODEL_POWER, 32'd65536, 32'd65536, 32'd4096, 32'd65536, 0);
    send_lag(32'd12345, 0, 0);
    load_setting(vse_pkg::MODEL_POWER, 32'd65536, 32'd65536, 32'd4096, 0, 16'hFFFF);
    send_lag(32'd12345, 0, 0);
    load_setting(vse_pkg::MODEL_POWER, 32'd65536, 32'd1000, 32'd9000, 32'd65536, 16'd384);
    send_lag(0, 1, 0);
    send_lag(32'h0003_0000, 0, 0);
    // gaussian with zero range flags an error
    load_setting(vse_pkg::MODEL_GAUSSIAN, 0, 32'd65536, 0, 32'd65536, 16'd256);
    send_lag(32'd100, 0, 0);
    // exponential far beyond range, exp underflows to zero
    load_setting(vse_pkg::MODEL_EXPONENTIAL, 1, 32'd65536, 32'd100, 32'd65536, 16'd256);
    send_lag(32'hFFFF_FFFF, 1, 0);
    // logarithmic: zero lag and ordinary lags, then unit max lag (log zero)
    load_setting(vse_pkg::MODEL_LOG, 32'd65536, 32'd65536, 0, 32'h0010_0000, 16'd256);
    send_lag(0, 0, 0);
    send_lag(32'h0004_0000, 0, 0);
    send_lag(32'h0000_4000, 1, 0);
    load_setting(vse_pkg::MODEL_LOG, 32'd65536, 32'd65536, 0, 32'd65536, 16'd256);
    send_lag(32'h0004_0000, 0, 0);
    // unassigned selector
    load_setting(3'd7, 32'd65536, 32'd65536, 0, 32'd65536, 16'd256);
    send_lag(32'h0004_0000, 1, 0);

    // random settings, each with a burst of random lags
    for (int ph = 0; ph < 20; ph++) begin
      sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'(ph % 5);
      rng = (ph % 7 == 3) ? 32'hFFFF_FFFF : (ph % 7 == 5) ? 32'd1 : draw_level();
      sill = draw_level();
      nug = ($urandom_range(0, 2) == 0) ? sill : draw_level();
      maxlag = (ph % 6 == 2) ? 32'hFFFF_FFFF : draw_level();
      pexp = (ph % 5 == 4) ? 16'hFFFF : 16'($urandom_range(0, 1024));
      load_setting(sel, rng, sill, nug, maxlag, pexp);
      for (int i = 0; i < 87; i++)
        send_lag(draw_lag(rng, maxlag), 1'($urandom_range(0, 1)), draw_gap());
    end

    start = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);

    $display("%0d lags checked over %0d register settings, %0d with error set",
             sb.checked, phases + 1, sb.flagged);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/vse_pkg.sv
design/vse_log2.sv
design/variogram_semivariance_eval.sv
test/tb_top.sv
